[sv/kcst_pkg.sv]
// ----------------------------------------------------------------------------
// kcst_pkg
// Shared types and constants of the keyed count-and-sum table: payload
// structs of the item and result channels and default sizes.
// ----------------------------------------------------------------------------
package kcst_pkg;

  // Default table size and total accumulator width.
  localparam int unsigned TABLE_ENTRIES_DEF = 256;
  localparam int unsigned TOTAL_BITS_DEF    = 32;

  // Fixed field widths.
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned AMT_W   = 16;

  // Item kinds.
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // One input item.
  typedef struct packed {
    logic        kind;
    logic [63:0] group_key;
    logic [15:0] amount;
    logic [7:0]  read_index;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  entry_index;
    logic        entry_valid;
    logic [63:0] entry_key;
    logic [15:0] entry_count;
    logic [31:0] entry_total;
    logic        table_full;
    logic [8:0]  groups_in_use;
  } result_t;

endpackage

[sv/kcst_ram.sv]
// ----------------------------------------------------------------------------
// kcst_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. Contents are undefined until written.
// ----------------------------------------------------------------------------
module kcst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/keyed_count_and_sum_table.sv]
// ----------------------------------------------------------------------------
// keyed_count_and_sum_table
// Group-by aggregation table: counts records and sums amounts per 64-bit key.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the item channel (item_valid/item_ready, payload item).
//   A record item (kind 0) looks up its key among the filled entries, from
//   entry 0 upward, one entry per cycle out of a single table RAM. A hit
//   bumps the saturating count and total; a miss claims the next free entry;
//   a miss with the table full drops the record and flags table_full.
//   A read item (kind 1) returns the entry at read_index.
//   Every item yields exactly one transfer on the result channel
//   (result_valid/result_ready, payload result).
//   The block works on one item at a time. A read of a filled entry passes
//   through S_READ and S_EMIT, a read of an unfilled entry straight to
//   S_EMIT. A record compares at most TABLE_ENTRIES entries in S_SEARCH,
//   then goes on to S_UPDATE on a hit or S_CLAIM on a miss, then S_EMIT.
//   The result sits in an output register, so the next item is taken once
//   the result has moved into it, even while the receiver stalls; that
//   item's result then waits until the output register is free.
//   Reset empties the table at once (fill level to zero); no clearing pass.
// ----------------------------------------------------------------------------
module keyed_count_and_sum_table #(
  parameter int unsigned TABLE_ENTRIES = kcst_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned TOTAL_BITS    = kcst_pkg::TOTAL_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  kcst_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output kcst_pkg::result_t result
);

  localparam int unsigned IW   = $clog2(TABLE_ENTRIES);
  localparam int unsigned FW   = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned TB   = TOTAL_BITS;
  localparam int unsigned CW   = kcst_pkg::COUNT_W;
  localparam int unsigned KW   = kcst_pkg::KEY_W;
  localparam int unsigned DW   = KW + CW + TB;
  localparam int unsigned SW   = ((TB > kcst_pkg::AMT_W) ? TB : kcst_pkg::AMT_W) + 1;
  localparam int unsigned RW   = (FW > 8) ? FW : 8;
  localparam logic [SW-1:0] TMAX = {{(SW - TB){1'b0}}, {TB{1'b1}}};
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_UPDATE = 6'b000100,
    S_READ   = 6'b001000,
    S_CLAIM  = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  // Saturating add of an amount to a total.
  function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] t,
                                            input logic [kcst_pkg::AMT_W-1:0] a);
    logic [SW-1:0] s;
    s = SW'(t) + SW'(a);
    if (s > TMAX) begin
      return TMAX[TB-1:0];
    end
    return s[TB-1:0];
  endfunction

  state_t            state, state_next;
  logic [FW-1:0]     fill, fill_next;
  logic [FW-1:0]     cmp_idx, cmp_idx_next;
  logic [FW-1:0]     cmp_inc;
  kcst_pkg::item_t   cur;
  kcst_pkg::result_t pend, pend_next;

  logic              ram_wr_en;
  logic [IW-1:0]     ram_wr_addr;
  logic [DW-1:0]     ram_wr_data;
  logic              ram_rd_en;
  logic [IW-1:0]     ram_rd_addr;
  logic [DW-1:0]     ram_rd_data;

  logic [KW-1:0]     rd_key;
  logic [CW-1:0]     rd_count;
  logic [TB-1:0]     rd_total;
  logic [CW-1:0]     upd_count;
  logic [TB-1:0]     upd_total;
  logic [TB-1:0]     new_total;
  logic              item_xfer;
  logic              in_range;
  logic              out_free;

  assign rd_key   = ram_rd_data[DW-1 -: KW];
  assign rd_count = ram_rd_data[TB +: CW];
  assign rd_total = ram_rd_data[TB-1:0];

  assign item_xfer = item_valid && item_ready;
  assign item_ready = (state == S_IDLE);
  assign in_range  = (RW'(item.read_index) < RW'(fill));
  assign cmp_inc   = cmp_idx + 1'b1;
  assign out_free  = !result_valid || result_ready;

  assign upd_count = (rd_count == CMAX) ? rd_count : rd_count + 1'b1;
  assign upd_total = sat_add(rd_total, cur.amount);
  assign new_total = sat_add('0, cur.amount);

  // Table RAM: key, count and total of each entry in one word.
  kcst_ram #(
    .WIDTH(DW),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // Sequencer: search, read-modify-write and result formation.
  always_comb begin
    state_next   = state;
    fill_next    = fill;
    cmp_idx_next = cmp_idx;
    pend_next    = pend;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = cmp_idx[IW-1:0];
    ram_wr_data  = {rd_key, upd_count, upd_total};
    ram_rd_en    = 1'b0;
    ram_rd_addr  = cmp_inc[IW-1:0];
    case (state)
      S_IDLE: begin
        if (item_xfer) begin
          cmp_idx_next = '0;
          if (item.kind == kcst_pkg::KIND_READ) begin
            if (in_range) begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = IW'(item.read_index);
              state_next  = S_READ;
            end else begin
              pend_next               = '0;
              pend_next.entry_index   = item.read_index;
              pend_next.groups_in_use = 9'(fill);
              state_next              = S_EMIT;
            end
          end else if (fill == '0) begin
            state_next = S_CLAIM;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
            state_next  = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        // The RAM output holds entry cmp_idx; the next entry is fetched
        // in the same cycle unless the search ends here.
        if (rd_key == cur.group_key) begin
          state_next = S_UPDATE;
        end else if (cmp_inc == fill) begin
          state_next = S_CLAIM;
        end else begin
          ram_rd_en    = 1'b1;
          cmp_idx_next = cmp_inc;
        end
      end
      S_UPDATE: begin
        ram_wr_en               = 1'b1;
        pend_next.entry_index   = 8'(cmp_idx);
        pend_next.entry_valid   = 1'b1;
        pend_next.entry_key     = rd_key;
        pend_next.entry_count   = upd_count;
        pend_next.entry_total   = 32'(upd_total);
        pend_next.table_full    = 1'b0;
        pend_next.groups_in_use = 9'(fill);
        state_next              = S_EMIT;
      end
      S_READ: begin
        pend_next.entry_index   = cur.read_index;
        pend_next.entry_valid   = 1'b1;
        pend_next.entry_key     = rd_key;
        pend_next.entry_count   = rd_count;
        pend_next.entry_total   = 32'(rd_total);
        pend_next.table_full    = 1'b0;
        pend_next.groups_in_use = 9'(fill);
        state_next              = S_EMIT;
      end
      S_CLAIM: begin
        if (fill == FW'(TABLE_ENTRIES)) begin
          pend_next               = '0;
          pend_next.table_full    = 1'b1;
          pend_next.groups_in_use = 9'(fill);
        end else begin
          ram_wr_en               = 1'b1;
          ram_wr_addr             = fill[IW-1:0];
          ram_wr_data             = {cur.group_key, CW'(1), new_total};
          fill_next               = fill + 1'b1;
          pend_next.entry_index   = 8'(fill);
          pend_next.entry_valid   = 1'b1;
          pend_next.entry_key     = cur.group_key;
          pend_next.entry_count   = CW'(1);
          pend_next.entry_total   = 32'(new_total);
          pend_next.table_full    = 1'b0;
          pend_next.groups_in_use = 9'(fill + 1'b1);
        end
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fill    <= '0;
      cmp_idx <= '0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      cmp_idx <= cmp_idx_next;
    end
  end

  // Item and pending result registers.
  always_ff @(posedge clk) begin
    if (item_xfer) begin
      cur <= item;
    end
    pend <= pend_next;
  end

  // Output register: loaded from the pending result when it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      result <= pend;
    end
  end

  // The fill level never passes the table size.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(TABLE_ENTRIES))
    else $error("fill level beyond table size");

  // The search pointer stays inside the filled region.
  a_search_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (cmp_idx < fill))
    else $error("search pointer outside filled entries");

  // The fill level only ever grows by one entry at a time.
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && fill != $past(fill)) |-> (fill == $past(fill) + 1'b1))
    else $error("fill level jumped");

  // A dropped record never reports an entry.
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.table_full) |-> !result.entry_valid)
    else $error("table_full together with a valid entry");

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyed count-and-sum table. Items are sent
// over the item channel with random gaps and results are taken with random
// back-pressure. A local model of the table works out each expected result
// when its item transfer happens. Every result transfer is compared field
// by field against the oldest expected result. The tests cover directed
// corner cases, a run of one key with no idling on either side, random
// traffic on a partly filled table, filling the table until records are
// dropped, and random traffic on the full table.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES     = kcst_pkg::TABLE_ENTRIES_DEF;
  // Largest total at the default total width (2^32 - 1).
  localparam logic [31:0] TOTAL_MAX   = 32'hFFFF_FFFF;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
  localparam int unsigned STALL_LIMIT = 5000;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_ready;
  kcst_pkg::item_t   item         = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  kcst_pkg::result_t result;

  keyed_count_and_sum_table uut (
    .clk,
    .rst,
    .item_valid,
    .item_ready,
    .item,
    .result_valid,
    .result_ready,
    .result
  );

  // Model copy of the table contents.
  logic [63:0] tbl_keys   [ENTRIES];
  logic [15:0] tbl_counts [ENTRIES];
  logic [31:0] tbl_totals [ENTRIES];
  int unsigned tbl_fill = 0;

  kcst_pkg::result_t pending_results [$];
  int unsigned       fail_count   = 0;
  int unsigned       quiet_cycles = 0;
  bit                idle_on      = 1'b1;

  always #4 clk = ~clk;

  // Position of a key among the filled entries, or -1 when absent.
  function automatic int key_slot(input logic [63:0] k);
    for (int i = 0; i < int'(tbl_fill); i++) begin
      if (tbl_keys[i] == k) return i;
    end
    return -1;
  endfunction

  // Applies one item to the model table and returns the result it yields.
  function automatic kcst_pkg::result_t aggregate(input kcst_pkg::item_t it);
    kcst_pkg::result_t r;
    int                slot;
    logic [32:0]       sum;
    r = '0;
    if (it.kind == kcst_pkg::KIND_READ) begin
      r.entry_index = it.read_index;
      if (it.read_index < tbl_fill) begin
        r.entry_valid = 1'b1;
        r.entry_key   = tbl_keys[it.read_index];
        r.entry_count = tbl_counts[it.read_index];
        r.entry_total = tbl_totals[it.read_index];
      end
    end else begin
      slot = key_slot(it.group_key);
      // A miss claims the next free entry, starting from zero.
      if (slot < 0 && tbl_fill < ENTRIES) begin
        slot             = int'(tbl_fill);
        tbl_keys[slot]   = it.group_key;
        tbl_counts[slot] = '0;
        tbl_totals[slot] = '0;
        tbl_fill++;
      end
      if (slot < 0) begin
        r.table_full = 1'b1;
      end else begin
        if (tbl_counts[slot] != COUNT_MAX) tbl_counts[slot]++;
        sum = {1'b0, tbl_totals[slot]} + it.amount;
        tbl_totals[slot] = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[31:0];
        r.entry_index = 8'(slot);
        r.entry_valid = 1'b1;
        r.entry_key   = tbl_keys[slot];
        r.entry_count = tbl_counts[slot];
        r.entry_total = tbl_totals[slot];
      end
    end
    r.groups_in_use = 9'(tbl_fill);
    return r;
  endfunction

  // A random key that no filled entry holds yet.
  function automatic logic [63:0] fresh_key();
    logic [63:0] k;
    do k = {$urandom, $urandom}; while (key_slot(k) >= 0);
    return k;
  endfunction

  // Amounts lean toward the extremes now and then.
  function automatic logic [15:0] pick_amount();
    case ($urandom_range(9))
      0: begin
        return 16'h0000;
      end
      1: begin
        return 16'hFFFF;
      end
      default: begin
        return 16'($urandom);
      end
    endcase
  endfunction

  // Unused fields of each kind get random values, since the block ignores them.
  function automatic kcst_pkg::item_t record_item(input logic [63:0] k,
                                                  input logic [15:0] amt);
    kcst_pkg::item_t it;
    it.kind       = kcst_pkg::KIND_RECORD;
    it.group_key  = k;
    it.amount     = amt;
    it.read_index = 8'($urandom);
    return it;
  endfunction

  function automatic kcst_pkg::item_t read_item(input logic [7:0] idx);
    kcst_pkg::item_t it;
    it.kind       = kcst_pkg::KIND_READ;
    it.group_key  = {$urandom, $urandom};
    it.amount     = 16'($urandom);
    it.read_index = idx;
    return it;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // Drives one item, waits for its transfer and records the expected result.
  task automatic send_item(input kcst_pkg::item_t it);
    if (idle_on) begin
      while ($urandom_range(99) < 24) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    pending_results.push_back(aggregate(it));
  endtask

  // Holds the sender off until every expected result has arrived.
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin : result_monitor
    kcst_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $error("result transfer with nothing expected, entry_index %0h", result.entry_index);
      end else begin
        want = pending_results.pop_front();
        check_field("entry_index", want.entry_index, result.entry_index);
        check_field("entry_valid", want.entry_valid, result.entry_valid);
        check_field("entry_key", want.entry_key, result.entry_key);
        check_field("entry_count", want.entry_count, result.entry_count);
        check_field("entry_total", want.entry_total, result.entry_total);
        check_field("table_full", want.table_full, result.table_full);
        check_field("groups_in_use", want.groups_in_use, result.groups_in_use);
      end
    end
    result_ready <= !rst && (!idle_on || $urandom_range(99) >= 24);
  end

  // Watchdog: too many cycles without any transfer ends the run.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Empty-table reads, key zero, all-ones key, extreme amounts, hits and
  // reads of filled and unfilled entries.
  task automatic test_directed();
    send_item(read_item(8'd0));
    send_item(read_item(8'd255));
    send_item(record_item(64'd0, 16'h0000));
    send_item(record_item('1, 16'hFFFF));
    send_item(record_item(64'd0, 16'hFFFF));
    send_item(record_item('1, 16'h0000));
    send_item(record_item(64'h8000_0000_0000_0001, 16'h0001));
    send_item(record_item(64'h0000_0000_0000_0001, 16'h8000));
    for (int i = 0; i < 5; i++) send_item(read_item(8'(i)));
    send_item(read_item(8'd255));
  endtask

  // One key recorded back to back with the largest amount, then read back.
  // Neither side idles here, which gives a long run of gapless transfers.
  task automatic test_repeated_key();
    logic [63:0] k;
    k       = fresh_key();
    idle_on = 1'b0;
    for (int n = 0; n < 40; n++) send_item(record_item(k, 16'hFFFF));
    idle_on = 1'b1;
    send_item(read_item(8'(key_slot(k))));
  endtask

  // Mix of hits on stored keys, new keys, arbitrary keys and reads.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned pick;
    for (int n = 0; n < int'(n_items); n++) begin
      pick = $urandom_range(99);
      if ($urandom_range(79) == 0) wait_drained();
      if (pick < 40 && tbl_fill > 0) begin
        send_item(record_item(tbl_keys[$urandom_range(tbl_fill - 1)], pick_amount()));
      end else if (pick < 60) begin
        send_item(record_item(fresh_key(), pick_amount()));
      end else if (pick < 65) begin
        send_item(record_item({$urandom, $urandom}, pick_amount()));
      end else if (pick < 82) begin
        send_item(read_item(8'($urandom)));
      end else begin
        send_item(read_item(8'($urandom_range(tbl_fill))));
      end
    end
  endtask

  // Fills every entry, then sends new keys that must be dropped, a hit on
  // the last entry (longest search) and reads at both ends.
  task automatic test_fill_and_overflow();
    while (tbl_fill < ENTRIES) begin
      if ($urandom_range(15) == 0) begin
        send_item(read_item(8'($urandom)));
      end else begin
        send_item(record_item(fresh_key(), pick_amount()));
      end
    end
    for (int n = 0; n < 8; n++) send_item(record_item(fresh_key(), pick_amount()));
    send_item(record_item(tbl_keys[ENTRIES-1], pick_amount()));
    send_item(read_item(8'd255));
    send_item(read_item(8'd0));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_repeated_key();
    test_random_traffic(550);
    wait_drained();
    test_fill_and_overflow();
    test_random_traffic(350);
    wait_drained();
    // Any stray result would show up within one full search.
    repeat (ENTRIES + 16) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
sv/kcst_pkg.sv
sv/kcst_ram.sv
sv/keyed_count_and_sum_table.sv
bench/tb_top.sv
